// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL files, included by nec_ir_frame_encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/nec_enc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nec_enc_pkg;

    localparam int unsigned DUR_W       = 15;
    localparam int unsigned CODE_W      = 32;
    localparam int unsigned BITS_W      = 32;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned CFG_IDX_W   = 3;

    // slot 0 is the leader, slots 1..32 carry bits, slot 33 is the stop item
    localparam logic [IDX_W-1:0] IDX_LEADER = 6'd0;
    localparam logic [IDX_W-1:0] IDX_STOP   = 6'd33;

    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_MARK    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_SPACE   = 3'd6;

    localparam logic [DUR_W-1:0] RST_LEADER_MARK  = 15'd9000;
    localparam logic [DUR_W-1:0] RST_LEADER_SPACE = 15'd4500;
    localparam logic [DUR_W-1:0] RST_BIT_MARK     = 15'd560;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 15'd1690;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 15'd560;
    localparam logic [DUR_W-1:0] RST_STOP_MARK    = 15'd560;
    localparam logic [DUR_W-1:0] RST_STOP_SPACE   = 15'h7fff;

    typedef struct packed {
        logic [DUR_W-1:0] leader_mark;
        logic [DUR_W-1:0] leader_space;
        logic [DUR_W-1:0] bit_mark;
        logic [DUR_W-1:0] one_space;
        logic [DUR_W-1:0] zero_space;
        logic [DUR_W-1:0] stop_mark;
        logic [DUR_W-1:0] stop_space;
    } t_cfg;

    typedef enum logic [1:0] {
        KIND_LEADER = 2'd0,
        KIND_BIT    = 2'd1,
        KIND_STOP   = 2'd2
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  bit_val;
    } t_slot;

endpackage

`default_nettype wire

// ===== design/nec_ir_frame_encoder.sv =====
// The first pulse item leaves via the sequencer registers and the output register.
// Throughput: 34 pulse items per code, one per cycle; a new request is taken
// while the stop item is being formed, so codes follow each other back to back.
// The rate is set by the 34-slot frame counter. Results cannot be stalled.
// Reset (synchronous, active low) loads the default timings and idles the frame.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nec_ir_frame_encoder
    import nec_enc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [CODE_W-1:0]    i_send_code,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DUR_W-1:0]     i_cfg_data,
    output logic                      o_valid,
    output logic [DUR_W-1:0]          o_mark_ticks,
    output logic [DUR_W-1:0]          o_space_ticks,
    output logic                      o_last_item
);

    t_cfg             cfg;
    t_slot            slot;
    logic             r_valid;
    logic [DUR_W-1:0] r_mark;
    logic [DUR_W-1:0] r_space;
    logic             r_last;
    logic [DUR_W-1:0] n_mark;
    logic [DUR_W-1:0] n_space;
    logic             n_last;

    assign o_cfg_ready = 1'b1;

    nec_enc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    nec_enc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_code  (i_send_code),
        .o_busy  (busy),
        .o_slot  (slot)
    );

    always_comb begin
        unique case (slot.kind)
            KIND_LEADER: begin
                n_mark  = cfg.leader_mark;
                n_space = cfg.leader_space;
                n_last  = 1'b0;
            end
            KIND_STOP: begin
                n_mark  = cfg.stop_mark;
                n_space = cfg.stop_space;
                n_last  = 1'b1;
            end
            default: begin
                n_mark  = cfg.bit_mark;
                n_space = slot.bit_val ? cfg.one_space : cfg.zero_space;
                n_last  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mark  <= n_mark;
        r_space <= n_space;
        r_last  <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_mark_ticks  = r_mark;
    assign o_space_ticks = r_space;
    assign o_last_item   = r_valid && r_last;

    `ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_busy_emits, i_clk, i_rst_n, busy, o_valid)
    `ASSERT_NEXT(a_single_stop, i_clk, i_rst_n, o_last_item, !o_last_item)
    `ASSERT_HOLDS(a_stop_while_free, i_clk, i_rst_n, !(slot.kind == KIND_STOP && busy))

endmodule

`default_nettype wire

// ===== design/nec_enc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nec_enc_cfg
    import nec_enc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DUR_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LEADER_MARK:  n_cfg.leader_mark  = i_cfg_data;
                REG_LEADER_SPACE: n_cfg.leader_space = i_cfg_data;
                REG_BIT_MARK:     n_cfg.bit_mark     = i_cfg_data;
                REG_ONE_SPACE:    n_cfg.one_space    = i_cfg_data;
                REG_ZERO_SPACE:   n_cfg.zero_space   = i_cfg_data;
                REG_STOP_MARK:    n_cfg.stop_mark    = i_cfg_data;
                REG_STOP_SPACE:   n_cfg.stop_space   = i_cfg_data;
                // drop writes to unmapped indexes
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader_mark  <= RST_LEADER_MARK;
            r_cfg.leader_space <= RST_LEADER_SPACE;
            r_cfg.bit_mark     <= RST_BIT_MARK;
            r_cfg.one_space    <= RST_ONE_SPACE;
            r_cfg.zero_space   <= RST_ZERO_SPACE;
            r_cfg.stop_mark    <= RST_STOP_MARK;
            r_cfg.stop_space   <= RST_STOP_SPACE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/nec_enc_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nec_enc_seq
    import nec_enc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [CODE_W-1:0] i_code,
    output logic                   o_busy,
    output t_slot                  o_slot
);

    logic [BITS_W-1:0] r_bits;
    logic [BITS_W-1:0] n_bits;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              r_active;
    logic              n_active;
    logic              accept;

    // free again while the stop slot is out, so frames run back to back
    assign o_busy = r_active && (r_idx != IDX_STOP);
    assign accept = i_start && !o_busy;

    always_comb begin
        n_bits   = r_bits;
        n_idx    = r_idx;
        n_active = r_active;
        if (accept) begin
            n_bits   = {i_code[31:16], i_code[15:8], ~i_code[15:8]};
            n_idx    = IDX_LEADER;
            n_active = 1'b1;
        end else if (r_active) begin
            if (r_idx == IDX_STOP) begin
                n_active = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
                // advance the bit line once a bit slot has gone out
                if (r_idx != IDX_LEADER) begin
                    n_bits = {r_bits[BITS_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= IDX_LEADER;
            r_active <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    always_comb begin
        o_slot.valid   = r_active;
        o_slot.bit_val = r_bits[BITS_W-1];
        if (r_idx == IDX_LEADER) begin
            o_slot.kind = KIND_LEADER;
        end else if (r_idx == IDX_STOP) begin
            o_slot.kind = KIND_STOP;
        end else begin
            o_slot.kind = KIND_BIT;
        end
    end

endmodule

`default_nettype wire
